// ===== hdl/ihd_pkg.sv =====
// Package for the integer to ASCII hex/decimal converter.
// Holds the request and response payload types, kind codes, ASCII constants
// and the digit helpers. Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package ihd_pkg;

    localparam int VALUE_W        = 64;
    localparam int VALUE_BITS_DEF = 64;
    localparam int DEC_BITS_DEF   = 32;
    localparam int NDIG_DEF       = 16;

    localparam logic [1:0] KIND_HEX_LO = 2'd0;
    localparam logic [1:0] KIND_HEX_UP = 2'd1;
    localparam logic [1:0] KIND_DEC    = 2'd2;

    localparam logic [6:0] ASCII_ZERO   = 7'd48;
    localparam logic [6:0] ALPHA_LO_OFF = 7'd87;
    localparam logic [6:0] ALPHA_UP_OFF = 7'd55;
    localparam logic [3:0] DIGIT_MAX    = 4'd9;

    typedef struct packed {
        logic [1:0]         req_type;
        logic [VALUE_W-1:0] value;
    } t_in_req;

    typedef struct packed {
        logic [6:0] ascii_char;
        logic       last_char;
    } t_out_rsp;

    typedef enum logic [1:0] {
        OP_HOLD,
        OP_DABBLE,
        OP_NIBBLE
    } t_step_op;

    typedef struct packed {
        t_step_op op;
        logic     bit_in;
    } t_step_ctl;

    // Number of decimal digits of the largest value that fits in bits.
    function automatic int dec_digits(input int bits);
        return ((bits * 1233) >> 12) + 1;
    endfunction

    function automatic int hex_digits(input int bits);
        return (bits + 3) / 4;
    endfunction

    function automatic logic [6:0] digit_to_ascii(input logic [3:0] d, input logic upper);
        logic [6:0] d7;
        d7 = {3'b000, d};
        if (d <= DIGIT_MAX) begin
            return ASCII_ZERO + d7;
        end else if (upper) begin
            return ALPHA_UP_OFF + d7;
        end else begin
            return ALPHA_LO_OFF + d7;
        end
    endfunction

endpackage

`default_nettype wire

// ===== hdl/ihd_step.sv =====
// Shared shift unit of the converter: one double-dabble step, one digit shift, or a hold.
// Depends on ihd_pkg for the step control type.
`timescale 1ns / 1ps
`default_nettype none

module ihd_step #(
    parameter int NDIG = ihd_pkg::NDIG_DEF
) (
    input  wire ihd_pkg::t_step_ctl i_ctl,
    input  wire logic [NDIG*4-1:0]  i_dig,
    output logic [NDIG*4-1:0]       o_dig
);
    import ihd_pkg::*;

    localparam int W = NDIG * 4;

    logic [W-1:0] adj;

    always_comb begin
        for (int i = 0; i < NDIG; i++) begin
            if (i_dig[4*i +: 4] >= 4'd5) begin
                adj[4*i +: 4] = i_dig[4*i +: 4] + 4'd3;
            end else begin
                adj[4*i +: 4] = i_dig[4*i +: 4];
            end
        end
    end

    always_comb begin
        case (i_ctl.op)
            OP_DABBLE: begin
                o_dig = {adj[W-2:0], i_ctl.bit_in};
            end
            OP_NIBBLE: begin
                o_dig = {i_dig[W-5:0], 4'b0000};
            end
            default: begin
                o_dig = i_dig;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== hdl/integer_to_ascii_hex_decimal_core.sv =====
// Top level of the integer to ASCII hex/decimal converter: sequencer,
// digit register and output register. Depends on ihd_pkg and ihd_step.
//
// A request carries a kind and a 64-bit value. Kind 0 gives lowercase hex and
// kind 1 uppercase hex of the low VALUE_BITS bits; kind 2 gives unsigned
// decimal of the low DEC_BITS bits; kind 3 is dropped without any response.
// Each response is one ASCII digit, most significant first, with no leading
// zeros; the final digit of a run has last_char set, and zero gives one '0'.
// The input is ready only while the sequencer is idle, so no new request is
// taken while a conversion runs. A hex request goes to the skip state, which
// drops leading zero digits one at a time, and then to the emit state, which
// gives one digit per cycle while the receiver does not stall. A decimal
// request first runs one double-dabble step per value bit through the shared
// shift unit and then takes the same skip and emit path. A dropped kind 3
// request leaves the sequencer idle. The first digit passes from the skip
// state through the emit state into the output register once that register
// is free. An output register holds each digit; while the receiver stalls the
// sequencer waits, and a new request is taken while the final digit of the
// previous one still waits. Reset empties the output register and returns the
// sequencer to idle.
`timescale 1ns / 1ps
`default_nettype none

module integer_to_ascii_hex_decimal_core #(
    parameter int VALUE_BITS = ihd_pkg::VALUE_BITS_DEF,
    parameter int DEC_BITS   = ihd_pkg::DEC_BITS_DEF
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_ready,
    input  wire ihd_pkg::t_in_req  i_in_req,
    output logic                   o_out_valid,
    input  wire logic              i_out_ready,
    output ihd_pkg::t_out_rsp      o_out_rsp
);
    import ihd_pkg::*;

    localparam int HEX_DIG = hex_digits(VALUE_BITS);
    localparam int DEC_DIG = dec_digits(DEC_BITS);
    localparam int NDIG    = (HEX_DIG > DEC_DIG) ? HEX_DIG : DEC_DIG;
    localparam int W       = NDIG * 4;
    localparam int MAXC    = (DEC_BITS > NDIG) ? DEC_BITS : NDIG;
    localparam int CW      = $clog2(MAXC + 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_DABBLE,
        S_SKIP,
        S_EMIT
    } t_state;

    t_state                r_state, n_state;
    logic [W-1:0]          r_dig, n_dig;
    logic [DEC_BITS-1:0]   r_bin, n_bin;
    logic [CW-1:0]         r_cnt, n_cnt;
    logic                  r_upper, n_upper;
    logic                  r_dec, n_dec;
    t_out_rsp              r_out, n_out;
    logic                  r_out_valid, n_out_valid;

    t_step_ctl             step_ctl;
    logic [W-1:0]          step_dig;
    logic [3:0]            top_dig;
    logic                  out_free;
    logic                  in_acc;

    ihd_step #(
        .NDIG (NDIG)
    ) u_step (
        .i_ctl (step_ctl),
        .i_dig (r_dig),
        .o_dig (step_dig)
    );

    assign top_dig     = r_dig[W-1 -: 4];
    assign out_free    = !r_out_valid || i_out_ready;
    assign o_in_ready  = (r_state == S_IDLE);
    assign in_acc      = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_rsp   = r_out;

    always_comb begin
        n_state         = r_state;
        n_dig           = r_dig;
        n_bin           = r_bin;
        n_cnt           = r_cnt;
        n_upper         = r_upper;
        n_dec           = r_dec;
        n_out           = r_out;
        n_out_valid     = r_out_valid;
        step_ctl.op     = OP_HOLD;
        step_ctl.bit_in = r_bin[DEC_BITS-1];

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_upper = (i_in_req.req_type == KIND_HEX_UP);
                    n_dec   = (i_in_req.req_type == KIND_DEC);
                    n_bin   = i_in_req.value[DEC_BITS-1:0];
                    case (i_in_req.req_type) inside
                        KIND_HEX_LO, KIND_HEX_UP: begin
                            n_dig                   = '0;
                            n_dig[VALUE_BITS-1:0]   = i_in_req.value[VALUE_BITS-1:0];
                            n_cnt                   = CW'(NDIG);
                            n_state                 = S_SKIP;
                        end
                        KIND_DEC: begin
                            n_dig   = '0;
                            n_cnt   = CW'(DEC_BITS);
                            n_state = S_DABBLE;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_DABBLE: begin
                step_ctl.op = OP_DABBLE;
                n_dig       = step_dig;
                n_bin       = {r_bin[DEC_BITS-2:0], 1'b0};
                n_cnt       = r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    n_cnt   = CW'(NDIG);
                    n_state = S_SKIP;
                end
            end
            S_SKIP: begin
                if (top_dig == 4'd0 && r_cnt != CW'(1)) begin
                    step_ctl.op = OP_NIBBLE;
                    n_dig       = step_dig;
                    n_cnt       = r_cnt - 1'b1;
                end else begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (out_free) begin
                    n_out_valid      = 1'b1;
                    n_out.ascii_char = digit_to_ascii(top_dig, r_upper);
                    n_out.last_char  = (r_cnt == CW'(1));
                    step_ctl.op      = OP_NIBBLE;
                    n_dig            = step_dig;
                    n_cnt            = r_cnt - 1'b1;
                    if (r_cnt == CW'(1)) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
        r_dig   <= n_dig;
        r_bin   <= n_bin;
        r_cnt   <= n_cnt;
        r_upper <= n_upper;
        r_dec   <= n_dec;
        r_out   <= n_out;
    end

    a_drop_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && !(i_in_req.req_type == KIND_HEX_LO || i_in_req.req_type == KIND_HEX_UP
                     || i_in_req.req_type == KIND_DEC)) |=> o_in_ready)
        else $error("Dropped kind left the sequencer busy.");

    a_busy_after_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && (i_in_req.req_type == KIND_HEX_LO || i_in_req.req_type == KIND_HEX_UP
                    || i_in_req.req_type == KIND_DEC)) |=> !o_in_ready)
        else $error("Accepted request did not start a conversion.");

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SKIP || r_state == S_EMIT) |->
            (r_cnt != '0 && r_cnt <= CW'(NDIG)))
        else $error("Digit count out of range.");

    a_dec_digit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT && r_dec) |-> (top_dig <= DIGIT_MAX))
        else $error("Decimal digit above nine.");

    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT && out_free && r_cnt == CW'(1)) |=>
            (o_in_ready && o_out_valid && o_out_rsp.last_char))
        else $error("Final digit not flagged or sequencer not idle.");

endmodule

`default_nettype wire

// ===== test/integer_to_ascii_hex_decimal_core_test.sv =====
// Testbench for integer_to_ascii_hex_decimal_core: a directed table followed by
// random requests, each digit checked against its row's expected string or a built-in digit predictor.
// Depends on ihd_pkg and the core; needs nothing else.
`timescale 1ns / 1ps

module integer_to_ascii_hex_decimal_core_test;

    import ihd_pkg::*;

    localparam logic [1:0] KIND_NONE  = 2'd3;
    localparam int         NUM_RANDOM = 310;
    localparam int         IDLE_LIMIT = 5000;
    localparam int         DRAIN_WAIT = 100;
    localparam int         LONG_HOLD  = 400;
    localparam logic [4:0] USE_MODEL  = 5'd31;
    localparam int         NDIR       = 24;

    localparam logic [VALUE_W-1:0] HEX_MASK = {VALUE_W{1'b1}} >> (VALUE_W - VALUE_BITS_DEF);
    localparam logic [VALUE_W-1:0] DEC_MASK = {VALUE_W{1'b1}} >> (VALUE_W - DEC_BITS_DEF);
    localparam logic [VALUE_W-1:0] ONES     = {VALUE_W{1'b1}};

    typedef struct packed {
        logic [1:0]   kind;
        logic [63:0]  value;
        logic [4:0]   nwant;
        logic [127:0] want;
    } t_dir_row;

    logic     i_clk;
    logic     i_rst_n;
    logic     i_in_valid;
    logic     o_in_ready;
    t_in_req  i_in_req;
    logic     o_out_valid;
    logic     i_out_ready;
    t_out_rsp o_out_rsp;

    t_out_rsp pending_chars[$];
    int       fail_count;
    bit       feed_done;
    bit       hold_off_req;
    int       idle_cycles;

    t_dir_row dir_rows [NDIR] = '{
        '{KIND_HEX_LO, 64'h0, 5'd1, "0"},
        '{KIND_HEX_UP, 64'h0, 5'd1, "0"},
        '{KIND_DEC, 64'h0, 5'd1, "0"},
        '{KIND_HEX_LO, ONES, 5'd16, "ffffffffffffffff"},
        '{KIND_HEX_UP, ONES, 5'd16, "FFFFFFFFFFFFFFFF"},
        '{KIND_DEC, ONES, 5'd10, "4294967295"},
        '{KIND_NONE, ONES, 5'd0, "0"},
        '{KIND_NONE, 64'h0, 5'd0, "0"},
        '{KIND_HEX_LO, 64'h8000000000000000, 5'd16, "8000000000000000"},
        '{KIND_HEX_UP, 64'h0123456789ABCDEF, 5'd15, "123456789ABCDEF"},
        '{KIND_HEX_LO, 64'hFEDCBA9876543210, 5'd16, "fedcba9876543210"},
        '{KIND_DEC, 64'hFFFFFFFF00000000, 5'd1, "0"},
        '{KIND_DEC, 64'd1, 5'd1, "1"},
        '{KIND_DEC, 64'd9, 5'd1, "9"},
        '{KIND_DEC, 64'd10, 5'd2, "10"},
        '{KIND_HEX_LO, 64'h9, 5'd1, "9"},
        '{KIND_HEX_LO, 64'ha, 5'd1, "a"},
        '{KIND_HEX_UP, 64'hf, 5'd1, "F"},
        '{KIND_HEX_LO, 64'h10, 5'd2, "10"},
        '{KIND_DEC, 64'h80000000, 5'd10, "2147483648"},
        '{KIND_HEX_UP, 64'hDEADBEEF, USE_MODEL, "0"},
        '{KIND_DEC, 64'h123456789ABCDEF0, USE_MODEL, "0"},
        '{KIND_HEX_LO, 64'd1, 5'd1, "1"},
        '{KIND_DEC, 64'd1000000000, USE_MODEL, "0"}
    };

    integer_to_ascii_hex_decimal_core i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_req    (i_in_req),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_rsp   (o_out_rsp)
    );

    always #1 i_clk = ~i_clk;

    function automatic void queue_digits(input t_in_req req);
        logic [VALUE_W-1:0] v;
        logic [6:0]         digs [20];
        logic [6:0]         off;
        logic [3:0]         d;
        int                 radix;
        int                 n;
        t_out_rsp           rsp;
        n = 0;
        case (req.req_type)
            KIND_HEX_LO: begin
                v = req.value & HEX_MASK;
                radix = 16;
                off = ALPHA_LO_OFF;
            end
            KIND_HEX_UP: begin
                v = req.value & HEX_MASK;
                radix = 16;
                off = ALPHA_UP_OFF;
            end
            KIND_DEC: begin
                v = req.value & DEC_MASK;
                radix = 10;
                off = ALPHA_LO_OFF;
            end
            default: begin
                return;
            end
        endcase
        do begin
            d = 4'(v % radix);
            digs[n] = (d <= 4'd9) ? ASCII_ZERO + 7'(d) : off + 7'(d);
            n++;
            v = v / radix;
        end while (v != 0 && n < 20);
        if (n > 16) begin
            n = 16;
        end
        for (int k = 0; k < n; k++) begin
            rsp.ascii_char = digs[n - 1 - k];
            rsp.last_char  = (k == n - 1);
            pending_chars.push_back(rsp);
        end
    endfunction

    function automatic logic [63:0] random_value(input logic [1:0] kind);
        logic [63:0] v;
        int          nb;
        v = {$urandom, $urandom};
        case ($urandom_range(0, 9))
            0: v = '0;
            1: v = ONES;
            default: begin
                nb = $urandom_range(1, 64);
                if (nb < 64) begin
                    v = v & ((64'd1 << nb) - 64'd1);
                end
                if (kind == KIND_DEC && $urandom_range(0, 1) == 1) begin
                    v[63:32] = $urandom;
                end
            end
        endcase
        return v;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) begin
            return 0;
        end else if (r < 85) begin
            return $urandom_range(1, 3);
        end else if (r < 95) begin
            return $urandom_range(4, 10);
        end
        return $urandom_range(20, 60);
    endfunction

    // Called at a falling edge; returns at the falling edge after acceptance.
    task automatic send_request(input t_in_req req, input int nwant, input logic [127:0] want);
        t_out_rsp rsp;
        i_in_valid <= 1'b1;
        i_in_req   <= req;
        do begin
            @(posedge i_clk);
        end while (!o_in_ready);
        if (nwant == USE_MODEL) begin
            queue_digits(req);
        end else begin
            for (int k = 0; k < nwant; k++) begin
                rsp.ascii_char = want[(nwant - 1 - k) * 8 +: 7];
                rsp.last_char  = (k == nwant - 1);
                pending_chars.push_back(rsp);
            end
        end
        @(negedge i_clk);
    endtask

    task automatic idle_sender(input int gap);
        t_in_req junk;
        if (gap > 0) begin
            junk.req_type = 2'($urandom);
            junk.value    = {$urandom, $urandom};
            i_in_valid <= 1'b0;
            i_in_req   <= junk;
            repeat (gap) @(negedge i_clk);
        end
    endtask

    initial begin
        t_in_req req;
        int      sent;
        wait (i_rst_n === 1'b1);
        @(negedge i_clk);
        for (int i = 0; i < NDIR; i++) begin
            req.req_type = dir_rows[i].kind;
            req.value    = dir_rows[i].value;
            send_request(req, dir_rows[i].nwant, dir_rows[i].want);
            idle_sender(pick_gap());
        end
        sent = 0;
        while (sent < NUM_RANDOM) begin
            if (sent == 100) begin
                i_in_valid <= 1'b0;
                @(negedge i_clk);
                while (pending_chars.size() != 0) begin
                    @(negedge i_clk);
                end
            end
            if (sent == 150) begin
                hold_off_req = 1'b1;
            end
            if ($urandom_range(0, 19) == 0) begin
                req.req_type = KIND_NONE;
            end else begin
                req.req_type = 2'($urandom_range(0, 2));
                sent++;
            end
            req.value = random_value(req.req_type);
            send_request(req, USE_MODEL, '0);
            // No gaps from the start of the long receiver hold-off, so the input backs up.
            if (sent >= 150 && sent < 170) begin
                idle_sender(0);
            end else begin
                idle_sender(pick_gap());
            end
        end
        i_in_valid <= 1'b0;
        feed_done = 1'b1;
    end

    initial begin
        int hold_left;
        int run_left;
        hold_left = 0;
        run_left  = 0;
        wait (i_rst_n === 1'b1);
        forever begin
            @(negedge i_clk);
            if (hold_left > 0) begin
                i_out_ready <= 1'b0;
                hold_left--;
            end else if (hold_off_req) begin
                hold_off_req = 1'b0;
                hold_left = LONG_HOLD - 1;
                i_out_ready <= 1'b0;
            end else if (run_left > 0) begin
                i_out_ready <= 1'b1;
                run_left--;
            end else if ($urandom_range(0, 2) == 0) begin
                hold_left = pick_gap();
                i_out_ready <= 1'b0;
            end else begin
                run_left = $urandom_range(0, 40);
                i_out_ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        t_out_rsp exp_rsp;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_chars.size() == 0) begin
                $error("unexpected response: ascii_char %h last_char %b",
                       o_out_rsp.ascii_char, o_out_rsp.last_char);
                fail_count++;
            end else begin
                exp_rsp = pending_chars.pop_front();
                if (o_out_rsp.ascii_char !== exp_rsp.ascii_char) begin
                    $error("ascii_char: expected %h, actual %h",
                           exp_rsp.ascii_char, o_out_rsp.ascii_char);
                    fail_count++;
                end
                if (o_out_rsp.last_char !== exp_rsp.last_char) begin
                    $error("last_char: expected %b, actual %b",
                           exp_rsp.last_char, o_out_rsp.last_char);
                    fail_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
                idle_cycles <= 0;
            end else if (idle_cycles >= IDLE_LIMIT) begin
                $display("integer_to_ascii_hex_decimal_core_test: FAIL");
                $finish;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    initial begin
        i_clk        = 1'b0;
        i_rst_n      = 1'b0;
        i_in_valid   = 1'b0;
        i_in_req     = '0;
        i_out_ready  = 1'b0;
        fail_count   = 0;
        feed_done    = 1'b0;
        hold_off_req = 1'b0;
        idle_cycles  = 0;
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;
        while (!(feed_done && pending_chars.size() == 0)) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (pending_chars.size() != 0) begin
            $error("%0d responses never arrived", pending_chars.size());
            fail_count++;
        end
        if (fail_count == 0) begin
            $display("integer_to_ascii_hex_decimal_core_test: PASS");
        end else begin
            $display("integer_to_ascii_hex_decimal_core_test: FAIL");
        end
        $finish;
    end

endmodule
